[rtl/lcdq_pkg.sv]
// Shared types, codes and command tables for the LCD command queue sequencer.
package lcdq_pkg;

  localparam int ACTION_W  = 2;
  localparam int ID_W      = 4;
  localparam int DATA_W    = 8;
  localparam int TICK_W    = 16;
  localparam int RELOAD_W  = 15;
  localparam int COUNT_W   = 7;
  localparam int ENTRY_W   = ID_W + DATA_W;
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = ACTION_W;
  localparam int M_TDATA_W = 40;

  localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

  localparam logic [ID_W-1:0] ID_SET_DDRAM  = 4'd7;
  localparam logic [ID_W-1:0] ID_WRITE_DATA = 4'd8;
  localparam logic [ID_W-1:0] ID_INIT_WAIT  = 4'd9;
  localparam logic [ID_W-1:0] NUM_IDS       = 4'd10;

  localparam logic [TICK_W-1:0] UNKNOWN_TIME = 16'hFFFF;

  typedef struct packed {
    logic load;
    logic finish;
    logic advance;
  } lcdq_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic flush_more;
    logic out_free;
  } lcdq_status_t;

  function automatic logic [DATA_W-1:0] id_mask(input logic [ID_W-1:0] id);
    logic [DATA_W-1:0] m;
    case (id)
      4'd0:    m = 8'h01;
      4'd1:    m = 8'h02;
      4'd2:    m = 8'h04;
      4'd3:    m = 8'h08;
      4'd4:    m = 8'h10;
      4'd5:    m = 8'h20;
      4'd6:    m = 8'h40;
      4'd7:    m = 8'h80;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [RELOAD_W-1:0] id_wait(input logic [ID_W-1:0] id);
    logic [RELOAD_W-1:0] w;
    case (id)
      4'd0, 4'd1: w = 15'd50;
      4'd5:       w = 15'd2550;
      4'd9:       w = 15'h7fff;
      default:    w = 15'd2;
    endcase
    return w;
  endfunction

endpackage

[rtl/lcdq_ram.sv]
// Generic single-port-write, registered-read RAM.
module lcdq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/lcdq_ctrl.sv]
// Controller state machine: item accept, execute, flush walk.
module lcdq_ctrl import lcdq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  lcdq_status_t status,
  output lcdq_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.is_flush && status.flush_more) begin
          cmd.advance = 1'b1;
          state_next  = ST_FETCH;
        end else if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_next = ST_EXEC;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/lcdq_dp.sv]
// Datapath: item registers, queue pointers, wait counter, ring RAM, output register.
module lcdq_dp import lcdq_pkg::*; #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  input  lcdq_cmd_t            cmd,
  output lcdq_status_t         status
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);

  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     cmd_id;
  logic [DATA_W-1:0]   cmd_data;
  logic [TICK_W-1:0]   elapsed;
  logic [IW-1:0]       head;
  logic [IW-1:0]       tail;
  logic [TICK_W-1:0]   remaining_wait;
  logic [RELOAD_W-1:0] reload_wait;

  logic [IW-1:0]       head_inc, tail_inc, head_next, tail_next;
  logic [TICK_W-1:0]   wait_next, wait_out;
  logic [RELOAD_W-1:0] reload_next;
  logic [ENTRY_W-1:0]  rd_data;
  logic [ID_W-1:0]     rd_id, eid;
  logic                empty, push_ok;
  logic                acc, strobe, rs;
  logic [DATA_W-1:0]   bus;
  logic [CW-1:0]       cnt_head, cnt_tail, count;

  lcdq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (cmd.finish && push_ok),
    .wr_addr (tail),
    .wr_data ({cmd_id, cmd_data}),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  assign head_inc = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
  assign empty    = (head == tail);
  assign rd_id    = rd_data[ENTRY_W-1:DATA_W];
  assign eid      = (rd_id >= NUM_IDS) ? ID_INIT_WAIT : rd_id;
  assign push_ok  = (action == ACT_PUSH) && (cmd_id < NUM_IDS) && (tail_inc != head);

  assign status.is_flush   = (action == ACT_FLUSH);
  assign status.flush_more = !empty && (rd_id == ID_WRITE_DATA || rd_id == ID_SET_DDRAM);
  assign status.out_free   = !m_tvalid || m_tready;

  always_comb begin
    acc         = push_ok;
    strobe      = 1'b0;
    rs          = 1'b0;
    bus         = '0;
    wait_next   = remaining_wait;
    reload_next = reload_wait;
    wait_out    = remaining_wait;
    head_next   = head;
    tail_next   = push_ok ? tail_inc : tail;
    if (action == ACT_TICK) begin
      if (remaining_wait != '0) begin
        if (elapsed == UNKNOWN_TIME) begin
          wait_next = {1'b0, reload_wait};
        end else if (elapsed >= remaining_wait) begin
          wait_next = '0;
        end else begin
          wait_next = remaining_wait - elapsed;
        end
        wait_out = wait_next;
      end else if (empty) begin
        wait_out = UNKNOWN_TIME;
      end else begin
        if (eid != ID_INIT_WAIT) begin
          strobe = 1'b1;
          rs     = (eid == ID_WRITE_DATA);
          bus    = rd_data[DATA_W-1:0] | id_mask(eid);
        end
        reload_next = id_wait(eid);
        wait_next   = {1'b0, reload_next};
        wait_out    = wait_next;
        head_next   = head_inc;
      end
    end
  end

  assign cnt_head = CW'(head_next);
  assign cnt_tail = CW'(tail_next);
  assign count    = (cnt_tail >= cnt_head) ? cnt_tail - cnt_head
                                           : cnt_tail + DEPTH_C - cnt_head;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action   <= s_tuser;
      cmd_id   <= s_tdata[3:0];
      cmd_data <= s_tdata[11:4];
      elapsed  <= s_tdata[27:12];
    end
    if (cmd.finish) begin
      m_tdata <= {6'd0, count[COUNT_W-1:0], wait_out, bus, rs, strobe, acc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      tail           <= '0;
      remaining_wait <= '0;
      reload_wait    <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cmd.advance) begin
        head <= head_inc;
      end else if (cmd.finish) begin
        head <= head_next;
      end
      if (cmd.finish) begin
        tail           <= tail_next;
        remaining_wait <= wait_next;
        reload_wait    <= reload_next;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/lcd_command_queue_sequencer_top.sv]
// Top level of the LCD command queue sequencer.
//
// Input channel (s_*): one item per action. s_tuser carries the action
// (push, tick, flush; code 3 does nothing). s_tdata carries cmd_id,
// cmd_data and elapsed. Every accepted item yields exactly one result on
// the output channel (m_*): accepted flag, strobed bus write (register
// select and byte), remaining wait and the queue fill after the item.
// Items are handled one at a time. For push, tick and no-op, the item is
// first registered while the ring RAM reads the head entry; then the state
// is updated and the output register loaded once it is free. A flush also
// drops entries one by one, each step advancing the head and waiting on the
// single registered read port of the ring RAM for the next entry. s_tready
// is high only while no item is in progress; with a result pending, the
// next item is still accepted and its result waits for the output register.
// When the receiver stalls, the result stays in the output register and
// further results wait for it to be taken. Reset empties the queue, clears
// the wait counters and drops any pending result. The ring RAM has no
// clearing pass; only written entries are ever read.
module lcd_command_queue_sequencer_top import lcdq_pkg::*; #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // cmd_id[3:0], cmd_data[11:4], elapsed[27:12], 0
  input  logic [S_TUSER_W-1:0] s_tuser,  // action[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // accepted[0], bus_strobe[1], reg_select[2],
                                         // bus_data[10:3], wait_ticks[26:11],
                                         // queue_count[33:27], 0
);

  lcdq_cmd_t    cmd;
  lcdq_status_t status;

  lcdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lcdq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

[rtl/lcdq_chk.sv]
// Port-level checks for the LCD command queue sequencer, bound to the top level.
module lcdq_chk import lcdq_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic [S_TUSER_W-1:0] s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  a_reset_no_result: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in progress");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> !m_tdata[2] && m_tdata[10:3] == '0)
    else $error("bus fields set without strobe");

  a_push_or_issue: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("push accepted and bus strobed in one result");

endmodule

bind lcd_command_queue_sequencer_top lcdq_chk u_lcdq_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
